@@ rtl/core/csrsms_pkg.sv @@
// ----------------------------------------------------------------------------
// csrsms_pkg
// Shared sizes, command codes, register indexes and status codes of the
// compressed sparse row matrix store.
// ----------------------------------------------------------------------------
package csrsms_pkg;

  localparam int MAX_ROWS    = 64;
  localparam int MAX_COLS    = 64;
  localparam int MAX_ENTRIES = 4096;

  localparam int VAL_W  = 32;
  localparam int DIM_W  = 7;
  localparam int ROW_W  = 6;
  localparam int COL_W  = 6;
  localparam int CNT_W  = 13;
  localparam int ENT_AW = 12;
  localparam int RS_AW  = 7;
  localparam int RS_DEPTH = MAX_ROWS + 1;
  localparam int ST_W   = 2;
  localparam int CFG_AW = 1;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic [CFG_AW-1:0] CFG_ROW_COUNT = 1'b0;
  localparam logic [CFG_AW-1:0] CFG_COL_COUNT = 1'b1;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [ST_W-1:0] ST_EXTRA = 2'd3;

endpackage

@@ rtl/core/csr_sparse_matrix_store_top.sv @@
// ----------------------------------------------------------------------------
// csr_sparse_matrix_store_top
// Loads a dense matrix word by word into compressed sparse row form and
// answers coordinate queries by scanning the stored entries of one row.
// ----------------------------------------------------------------------------
//
//  Channel  Handshake          Contents
//  -------  -----------------  ------------------------------------------
//  in_*     start, busy        command, element, last flag, row, column
//  out_*    out_strobe         value, status, nonzero total
//  cfg_*    cfg_we             index 0 row_count, index 1 col_count
//
// A load word is answered in the cycle after it is taken; busy stays low.
// An empty or out-of-range query also answers in the cycle after it is taken.
// An in-range query keeps busy high through S_LO, S_HI and S_SCAN, where the
// entries of that row are read up to the match or the row end (at most
// MAX_COLS), one per cycle from the single read port of the entry memory. Its
// result comes as busy falls, and a new word can be taken in that cycle.
// Reset is synchronous; no clearing pass is needed. Results cannot be stalled.

module csr_sparse_matrix_store_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic                              in_command,
  input  logic signed [csrsms_pkg::VAL_W-1:0] in_element_value,
  input  logic                              in_last_element,
  input  logic [csrsms_pkg::ROW_W-1:0]      in_query_row,
  input  logic [csrsms_pkg::COL_W-1:0]      in_query_col,
  output logic                              out_strobe,
  output logic signed [csrsms_pkg::VAL_W-1:0] out_read_value,
  output logic [csrsms_pkg::ST_W-1:0]       out_status,
  output logic [csrsms_pkg::CNT_W-1:0]      out_nonzero_total,
  input  logic                              cfg_we,
  input  logic [csrsms_pkg::CFG_AW-1:0]     cfg_index,
  input  logic [csrsms_pkg::DIM_W-1:0]      cfg_wdata
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_LO   = 2'd1;
  localparam logic [1:0] S_HI   = 2'd2;
  localparam logic [1:0] S_SCAN = 2'd3;

  localparam int EW = csrsms_pkg::VAL_W + csrsms_pkg::COL_W;

  // Memories: entry value with its column, and row end pointers.
  logic [EW-1:0]                  ent_mem [csrsms_pkg::MAX_ENTRIES];
  logic [csrsms_pkg::CNT_W-1:0]   rs_mem  [csrsms_pkg::RS_DEPTH];

  logic [EW-1:0]                  ent_rdata_r;
  logic [csrsms_pkg::CNT_W-1:0]   rs_rdata_r;
  logic                           ent_we;
  logic [csrsms_pkg::ENT_AW-1:0]  ent_waddr;
  logic [EW-1:0]                  ent_wdata;
  logic [csrsms_pkg::ENT_AW-1:0]  ent_raddr;
  logic                           rs_we;
  logic [csrsms_pkg::RS_AW-1:0]   rs_waddr;
  logic [csrsms_pkg::CNT_W-1:0]   rs_wdata;
  logic [csrsms_pkg::RS_AW-1:0]   rs_raddr;

  // Control state.
  logic [1:0]                     state_r, state_nxt;
  logic [csrsms_pkg::DIM_W-1:0]   row_count_r, col_count_r;
  logic                           ld_active_r, ld_active_nxt;
  logic [csrsms_pkg::DIM_W-1:0]   ld_rows_r, ld_rows_nxt;
  logic [csrsms_pkg::DIM_W-1:0]   ld_cols_r, ld_cols_nxt;
  logic [csrsms_pkg::DIM_W-1:0]   ld_row_r, ld_row_nxt;
  logic [csrsms_pkg::COL_W-1:0]   ld_col_r, ld_col_nxt;
  logic [csrsms_pkg::CNT_W-1:0]   nz_r, nz_nxt;
  logic [csrsms_pkg::DIM_W-1:0]   st_rows_r, st_rows_nxt;
  logic [csrsms_pkg::DIM_W-1:0]   st_cols_r, st_cols_nxt;
  logic [csrsms_pkg::DIM_W-1:0]   filled_r, filled_nxt;

  // Query state.
  logic [csrsms_pkg::ROW_W-1:0]   q_row_r, q_row_nxt;
  logic [csrsms_pkg::COL_W-1:0]   q_col_r, q_col_nxt;
  logic [csrsms_pkg::CNT_W-1:0]   idx_r, idx_nxt;
  logic [csrsms_pkg::CNT_W-1:0]   hi_r, hi_nxt;
  logic                           pend_r, pend_nxt;

  // Result register.
  logic                           strobe_r, strobe_nxt;
  logic [csrsms_pkg::VAL_W-1:0]   res_val_r, res_val_nxt;
  logic [csrsms_pkg::ST_W-1:0]    res_st_r, res_st_nxt;
  logic [csrsms_pkg::CNT_W-1:0]   res_nz_r, res_nz_nxt;

  logic                           accept;
  logic [csrsms_pkg::DIM_W-1:0]   qr_ext, qr_inc;

  // Load word working values.
  logic [csrsms_pkg::DIM_W-1:0]   l_rows, l_cols, l_row;
  logic [csrsms_pkg::DIM_W-1:0]   l_col_inc;
  logic [csrsms_pkg::COL_W-1:0]   l_col;
  logic [csrsms_pkg::CNT_W-1:0]   l_nz;
  logic                           l_extra;

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;
  assign qr_ext = {1'b0, q_row_r};
  assign qr_inc = qr_ext + csrsms_pkg::DIM_W'(1);

  always_comb begin
    state_nxt     = state_r;
    ld_active_nxt = ld_active_r;
    ld_rows_nxt   = ld_rows_r;
    ld_cols_nxt   = ld_cols_r;
    ld_row_nxt    = ld_row_r;
    ld_col_nxt    = ld_col_r;
    nz_nxt        = nz_r;
    st_rows_nxt   = st_rows_r;
    st_cols_nxt   = st_cols_r;
    filled_nxt    = filled_r;
    q_row_nxt     = q_row_r;
    q_col_nxt     = q_col_r;
    idx_nxt       = idx_r;
    hi_nxt        = hi_r;
    pend_nxt      = 1'b0;
    strobe_nxt    = 1'b0;
    res_val_nxt   = res_val_r;
    res_st_nxt    = res_st_r;
    res_nz_nxt    = res_nz_r;
    ent_we        = 1'b0;
    ent_waddr     = nz_r[csrsms_pkg::ENT_AW-1:0];
    ent_wdata     = {in_element_value, ld_col_r};
    ent_raddr     = idx_r[csrsms_pkg::ENT_AW-1:0];
    rs_we         = 1'b0;
    rs_waddr      = ld_row_r + csrsms_pkg::DIM_W'(1);
    rs_wdata      = nz_r;
    rs_raddr      = {1'b0, in_query_row};
    l_rows        = ld_rows_r;
    l_cols        = ld_cols_r;
    l_row         = ld_row_r;
    l_col         = ld_col_r;
    l_nz          = nz_r;
    l_col_inc     = '0;
    l_extra       = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (accept && in_command == csrsms_pkg::CMD_LOAD) begin
          // The first word after a completed load starts a fresh store.
          if (!ld_active_r) begin
            l_rows = (row_count_r > csrsms_pkg::DIM_W'(csrsms_pkg::MAX_ROWS)) ?
                     csrsms_pkg::DIM_W'(csrsms_pkg::MAX_ROWS) : row_count_r;
            l_cols = (col_count_r > csrsms_pkg::DIM_W'(csrsms_pkg::MAX_COLS)) ?
                     csrsms_pkg::DIM_W'(csrsms_pkg::MAX_COLS) : col_count_r;
            l_row  = '0;
            l_col  = '0;
            l_nz   = '0;
            st_rows_nxt = '0;
            st_cols_nxt = '0;
          end
          res_st_nxt = csrsms_pkg::ST_OK;
          l_extra = (l_rows == '0) || (l_cols == '0) || (l_row >= l_rows);
          if (l_extra) begin
            res_st_nxt = csrsms_pkg::ST_EXTRA;
          end else begin
            if (in_element_value != '0) begin
              if (l_nz < csrsms_pkg::CNT_W'(csrsms_pkg::MAX_ENTRIES)) begin
                ent_we    = 1'b1;
                ent_waddr = l_nz[csrsms_pkg::ENT_AW-1:0];
                ent_wdata = {in_element_value, l_col};
                l_nz      = l_nz + csrsms_pkg::CNT_W'(1);
              end else begin
                res_st_nxt = csrsms_pkg::ST_EXTRA;
              end
            end
            l_col_inc = {1'b0, l_col} + csrsms_pkg::DIM_W'(1);
            if (l_col_inc >= l_cols) begin
              rs_we    = 1'b1;
              rs_waddr = l_row + csrsms_pkg::DIM_W'(1);
              rs_wdata = l_nz;
              l_col    = '0;
              l_row    = l_row + csrsms_pkg::DIM_W'(1);
            end else begin
              l_col = l_col_inc[csrsms_pkg::COL_W-1:0];
            end
          end
          ld_active_nxt = 1'b1;
          ld_rows_nxt   = l_rows;
          ld_cols_nxt   = l_cols;
          ld_row_nxt    = l_row;
          ld_col_nxt    = l_col;
          nz_nxt        = l_nz;
          if (in_last_element) begin
            // Rows never reached end at the final count; filled marks them.
            st_rows_nxt   = l_rows;
            st_cols_nxt   = l_cols;
            filled_nxt    = l_row;
            ld_active_nxt = 1'b0;
            ld_row_nxt    = '0;
            ld_col_nxt    = '0;
          end
          strobe_nxt  = 1'b1;
          res_val_nxt = '0;
          res_nz_nxt  = l_nz;
        end else if (accept) begin
          res_val_nxt = '0;
          res_nz_nxt  = nz_r;
          if (st_rows_r == '0 || st_cols_r == '0) begin
            strobe_nxt = 1'b1;
            res_st_nxt = csrsms_pkg::ST_EMPTY;
          end else if ({1'b0, in_query_row} >= st_rows_r ||
                       {1'b0, in_query_col} >= st_cols_r) begin
            strobe_nxt = 1'b1;
            res_st_nxt = csrsms_pkg::ST_RANGE;
          end else begin
            q_row_nxt = in_query_row;
            q_col_nxt = in_query_col;
            state_nxt = S_LO;
          end
        end
      end
      S_LO: begin
        if (q_row_r == '0) begin
          idx_nxt = '0;
        end else if (qr_ext <= filled_r) begin
          idx_nxt = rs_rdata_r;
        end else begin
          idx_nxt = nz_r;
        end
        rs_raddr  = qr_inc;
        state_nxt = S_HI;
      end
      S_HI: begin
        hi_nxt    = (qr_inc <= filled_r) ? rs_rdata_r : nz_r;
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        // A read issued last cycle is checked while the next one goes out.
        if (pend_r && ent_rdata_r[csrsms_pkg::COL_W-1:0] == q_col_r) begin
          strobe_nxt  = 1'b1;
          res_val_nxt = ent_rdata_r[EW-1:csrsms_pkg::COL_W];
          res_st_nxt  = csrsms_pkg::ST_OK;
          state_nxt   = S_IDLE;
        end else if (idx_r < hi_r) begin
          ent_raddr = idx_r[csrsms_pkg::ENT_AW-1:0];
          idx_nxt   = idx_r + csrsms_pkg::CNT_W'(1);
          pend_nxt  = 1'b1;
        end else begin
          strobe_nxt  = 1'b1;
          res_val_nxt = '0;
          res_st_nxt  = csrsms_pkg::ST_OK;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ent_we) begin
      ent_mem[ent_waddr] <= ent_wdata;
    end
    ent_rdata_r <= ent_mem[ent_raddr];
  end

  always_ff @(posedge clk) begin
    if (rs_we) begin
      rs_mem[rs_waddr] <= rs_wdata;
    end
    rs_rdata_r <= rs_mem[rs_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      row_count_r <= '0;
      col_count_r <= '0;
      ld_active_r <= 1'b0;
      ld_rows_r   <= '0;
      ld_cols_r   <= '0;
      ld_row_r    <= '0;
      ld_col_r    <= '0;
      nz_r        <= '0;
      st_rows_r   <= '0;
      st_cols_r   <= '0;
      filled_r    <= '0;
      pend_r      <= 1'b0;
      strobe_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ld_active_r <= ld_active_nxt;
      ld_rows_r   <= ld_rows_nxt;
      ld_cols_r   <= ld_cols_nxt;
      ld_row_r    <= ld_row_nxt;
      ld_col_r    <= ld_col_nxt;
      nz_r        <= nz_nxt;
      st_rows_r   <= st_rows_nxt;
      st_cols_r   <= st_cols_nxt;
      filled_r    <= filled_nxt;
      pend_r      <= pend_nxt;
      strobe_r    <= strobe_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          csrsms_pkg::CFG_ROW_COUNT: row_count_r <= cfg_wdata;
          csrsms_pkg::CFG_COL_COUNT: col_count_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    q_row_r   <= q_row_nxt;
    q_col_r   <= q_col_nxt;
    idx_r     <= idx_nxt;
    hi_r      <= hi_nxt;
    res_val_r <= res_val_nxt;
    res_st_r  <= res_st_nxt;
    res_nz_r  <= res_nz_nxt;
  end

  assign out_strobe        = strobe_r;
  assign out_read_value    = res_val_r;
  assign out_status        = res_st_r;
  assign out_nonzero_total = res_nz_r;

`ifndef NO_ASSERTIONS
  a_no_strobe_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !(strobe_r && state_r != S_IDLE))
    else $error("result strobe while a query is still scanning");

  a_accept_makes_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (strobe_r || state_r == S_LO))
    else $error("accepted word neither answered nor scanned");

  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    nz_r <= csrsms_pkg::CNT_W'(csrsms_pkg::MAX_ENTRIES))
    else $error("nonzero count beyond store size");

  a_scan_in_row: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (hi_r <= nz_r))
    else $error("row end pointer beyond stored entries");

  a_nonok_reads_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (strobe_r && res_st_r != csrsms_pkg::ST_OK) |-> (res_val_r == '0))
    else $error("non-ok result carries a value");
`endif

endmodule

@@ verif/tb_csr_sparse_matrix_store_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_csr_sparse_matrix_store_top
// Drives load and query words into the sparse matrix store and checks every
// result word against its typed expectation or a cycle-free model of the
// bench's compressed row store. A short directed table runs first, then
// random phases that each set the dimensions, stream a load (full, short or
// with extra elements) and ask a batch of coordinates, idling at several rates.
// ----------------------------------------------------------------------------

module tb_csr_sparse_matrix_store_top;

  localparam int CYCLE_LIMIT = 500000;
  localparam int RAND_WORDS  = 410;
  localparam int TAIL_CYCLES = 80;
  localparam int DIR_LEN     = 28;

  typedef struct packed {
    logic [csrsms_pkg::VAL_W-1:0] value;
    logic [csrsms_pkg::ST_W-1:0]  status;
    logic [csrsms_pkg::CNT_W-1:0] nz;
  } word_result_t;

  typedef enum logic {DO_CFG, DO_WORD} row_kind_t;

  typedef struct packed {
    row_kind_t                    kind;
    logic [csrsms_pkg::DIM_W-1:0] cfg_rows;
    logic [csrsms_pkg::DIM_W-1:0] cfg_cols;
    logic                         cmd;
    logic [csrsms_pkg::VAL_W-1:0] value;
    logic                         last;
    logic [csrsms_pkg::ROW_W-1:0] qr;
    logic [csrsms_pkg::COL_W-1:0] qc;
    logic                         typed;
    word_result_t                 want;
  } stim_row_t;

  localparam word_result_t NO_RES = '0;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          start = 1'b0;
  logic                          busy;
  logic                          in_command = csrsms_pkg::CMD_LOAD;
  logic [csrsms_pkg::VAL_W-1:0]  in_element_value = '0;
  logic                          in_last_element = 1'b0;
  logic [csrsms_pkg::ROW_W-1:0]  in_query_row = '0;
  logic [csrsms_pkg::COL_W-1:0]  in_query_col = '0;
  logic                          out_strobe;
  logic [csrsms_pkg::VAL_W-1:0]  out_read_value;
  logic [csrsms_pkg::ST_W-1:0]   out_status;
  logic [csrsms_pkg::CNT_W-1:0]  out_nonzero_total;
  logic                          cfg_we = 1'b0;
  logic [csrsms_pkg::CFG_AW-1:0] cfg_index = csrsms_pkg::CFG_ROW_COUNT;
  logic [csrsms_pkg::DIM_W-1:0]  cfg_wdata = '0;

  csr_sparse_matrix_store_top dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_command        (in_command),
    .in_element_value  (in_element_value),
    .in_last_element   (in_last_element),
    .in_query_row      (in_query_row),
    .in_query_col      (in_query_col),
    .out_strobe        (out_strobe),
    .out_read_value    (out_read_value),
    .out_status        (out_status),
    .out_nonzero_total (out_nonzero_total),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  always #10 clk = ~clk;

  // Bench copy of the compressed row store.
  logic [csrsms_pkg::VAL_W-1:0] nz_vals [csrsms_pkg::MAX_ENTRIES];
  logic [csrsms_pkg::COL_W-1:0] nz_cols [csrsms_pkg::MAX_ENTRIES];
  int               row_ptr [csrsms_pkg::RS_DEPTH];
  int               fill_row, fill_col, nz_seen;
  int               fill_rows, fill_cols, shown_rows, shown_cols;
  int               dim_rows_reg, dim_cols_reg;
  bit               filling;

  word_result_t     pending_results [$];
  word_result_t     head_result;
  int               mismatches;
  int               words_sent;
  int               idle_pct;
  int               cycles;

  // Directed words. Rows with typed expectations are checked against those
  // values; the rest go through the store model.
  stim_row_t dir_tab [0:DIR_LEN-1] = '{
    '{DO_WORD, 7'd0, 7'd0, csrsms_pkg::CMD_QUERY, 32'h0, 1'b0, 6'd0, 6'd0, 1'b1,
      '{32'h0, csrsms_pkg::ST_EMPTY, 13'd0}},
    '{DO_WORD, 7'd0, 7'd0, csrsms_pkg::CMD_LOAD, 32'h5, 1'b1, 6'd0, 6'd0, 1'b1,
      '{32'h0, csrsms_pkg::ST_EXTRA, 13'd0}},
    '{DO_WORD, 7'd0, 7'd0, csrsms_pkg::CMD_QUERY, 32'h0, 1'b0, 6'd0, 6'd0, 1'b1,
      '{32'h0, csrsms_pkg::ST_EMPTY, 13'd0}},
    '{DO_CFG, 7'd2, 7'd3, csrsms_pkg::CMD_LOAD, 32'h0, 1'b0, 6'd0, 6'd0, 1'b0,
      NO_RES},
    '{DO_WORD, 7'd0, 7'd0, csrsms_pkg::CMD_LOAD, 32'h7FFF_FFFF, 1'b0, 6'd0, 6'd0,
      1'b0, NO_RES},
    '{DO_WORD, 7'd0, 7'd0, csrsms_pkg::CMD_LOAD, 32'h0, 1'b0, 6'd0, 6'd0, 1'b0,
      NO_RES},
    '{DO_WORD, 7'd0, 7'd0, csrsms_pkg::CMD_LOAD, 32'h8000_0000, 1'b0, 6'd0, 6'd0,
      1'b0, NO_RES},
    // A query in the middle of a load sees the cleared store.
    '{DO_WORD, 7'd0, 7'd0, csrsms_pkg::CMD_QUERY, 32'h0, 1'b0, 6'd0, 6'd0, 1'b1,
      '{32'h0, csrsms_pkg::ST_EMPTY, 13'd2}},
    '{DO_WORD, 7'd0, 7'd0, csrsms_pkg::CMD_LOAD, 32'hFFFF_FFFF, 1'b0, 6'd0, 6'd0,
      1'b0, NO_RES},
    '{DO_WORD, 7'd0, 7'd0, csrsms_pkg::CMD_LOAD, 32'h0, 1'b0, 6'd0, 6'd0, 1'b0,
      NO_RES},
    '{DO_WORD, 7'd0, 7'd0, csrsms_pkg::CMD_LOAD, 32'h1, 1'b0, 6'd0, 6'd0, 1'b0,
      NO_RES},
    '{DO_WORD, 7'd0, 7'd0, csrsms_pkg::CMD_LOAD, 32'h9, 1'b1, 6'd0, 6'd0, 1'b1,
      '{32'h0, csrsms_pkg::ST_EXTRA, 13'd4}},
    '{DO_WORD, 7'd0, 7'd0, csrsms_pkg::CMD_QUERY, 32'h0, 1'b0, 6'd0, 6'd0, 1'b0,
      NO_RES},
    '{DO_WORD, 7'd0, 7'd0, csrsms_pkg::CMD_QUERY, 32'h0, 1'b0, 6'd0, 6'd2, 1'b0,
      NO_RES},
    '{DO_WORD, 7'd0, 7'd0, csrsms_pkg::CMD_QUERY, 32'h0, 1'b0, 6'd1, 6'd1, 1'b0,
      NO_RES},
    '{DO_WORD, 7'd0, 7'd0, csrsms_pkg::CMD_QUERY, 32'h0, 1'b0, 6'd1, 6'd2, 1'b0,
      NO_RES},
    '{DO_WORD, 7'd0, 7'd0, csrsms_pkg::CMD_QUERY, 32'h0, 1'b0, 6'd2, 6'd0, 1'b1,
      '{32'h0, csrsms_pkg::ST_RANGE, 13'd4}},
    '{DO_WORD, 7'd0, 7'd0, csrsms_pkg::CMD_QUERY, 32'h0, 1'b0, 6'd0, 6'd3, 1'b1,
      '{32'h0, csrsms_pkg::ST_RANGE, 13'd4}},
    '{DO_WORD, 7'd0, 7'd0, csrsms_pkg::CMD_QUERY, 32'h0, 1'b0, 6'd63, 6'd63, 1'b1,
      '{32'h0, csrsms_pkg::ST_RANGE, 13'd4}},
    // Oversized dimensions clamp to 64 by 64; a two-element load is short.
    '{DO_CFG, 7'd127, 7'd127, csrsms_pkg::CMD_LOAD, 32'h0, 1'b0, 6'd0, 6'd0, 1'b0,
      NO_RES},
    '{DO_WORD, 7'd0, 7'd0, csrsms_pkg::CMD_LOAD, 32'h2A, 1'b0, 6'd0, 6'd0, 1'b0,
      NO_RES},
    '{DO_WORD, 7'd0, 7'd0, csrsms_pkg::CMD_LOAD, 32'h7, 1'b1, 6'd0, 6'd0, 1'b0,
      NO_RES},
    '{DO_WORD, 7'd0, 7'd0, csrsms_pkg::CMD_QUERY, 32'h0, 1'b0, 6'd0, 6'd1, 1'b0,
      NO_RES},
    '{DO_WORD, 7'd0, 7'd0, csrsms_pkg::CMD_QUERY, 32'h0, 1'b0, 6'd63, 6'd63, 1'b1,
      '{32'h0, csrsms_pkg::ST_OK, 13'd2}},
    // Zero columns: every element is extra and the result is empty.
    '{DO_CFG, 7'd64, 7'd0, csrsms_pkg::CMD_LOAD, 32'h0, 1'b0, 6'd0, 6'd0, 1'b0,
      NO_RES},
    '{DO_WORD, 7'd0, 7'd0, csrsms_pkg::CMD_LOAD, 32'h3, 1'b0, 6'd0, 6'd0, 1'b1,
      '{32'h0, csrsms_pkg::ST_EXTRA, 13'd0}},
    '{DO_WORD, 7'd0, 7'd0, csrsms_pkg::CMD_LOAD, 32'h4, 1'b1, 6'd0, 6'd0, 1'b1,
      '{32'h0, csrsms_pkg::ST_EXTRA, 13'd0}},
    '{DO_WORD, 7'd0, 7'd0, csrsms_pkg::CMD_QUERY, 32'h0, 1'b0, 6'd0, 6'd0, 1'b1,
      '{32'h0, csrsms_pkg::ST_EMPTY, 13'd0}}
  };

  function automatic word_result_t csr_predict(logic cmd,
                                               logic [csrsms_pkg::VAL_W-1:0] v,
                                               logic last, int qr, int qc);
    word_result_t r;
    int           i, lo, hi;
    r = '0;
    r.status = csrsms_pkg::ST_OK;
    if (cmd == csrsms_pkg::CMD_LOAD) begin
      if (!filling) begin
        filling    = 1'b1;
        nz_seen    = 0;
        shown_rows = 0;
        shown_cols = 0;
        fill_row   = 0;
        fill_col   = 0;
        fill_rows  = (dim_rows_reg > csrsms_pkg::MAX_ROWS) ?
                     csrsms_pkg::MAX_ROWS : dim_rows_reg;
        fill_cols  = (dim_cols_reg > csrsms_pkg::MAX_COLS) ?
                     csrsms_pkg::MAX_COLS : dim_cols_reg;
        row_ptr[0] = 0;
      end
      if (fill_rows == 0 || fill_cols == 0 || fill_row >= fill_rows) begin
        r.status = csrsms_pkg::ST_EXTRA;
      end else begin
        if (v != '0) begin
          if (nz_seen < csrsms_pkg::MAX_ENTRIES) begin
            nz_vals[nz_seen] = v;
            nz_cols[nz_seen] = fill_col[csrsms_pkg::COL_W-1:0];
            nz_seen++;
          end else begin
            r.status = csrsms_pkg::ST_EXTRA;
          end
        end
        fill_col++;
        if (fill_col >= fill_cols) begin
          fill_col = 0;
          row_ptr[fill_row + 1] = nz_seen;
          fill_row++;
        end
      end
      if (last) begin
        // Rows never reached by a short load end up empty.
        for (i = fill_row; i < fill_rows; i++) row_ptr[i + 1] = nz_seen;
        shown_rows = fill_rows;
        shown_cols = fill_cols;
        filling    = 1'b0;
        fill_row   = 0;
        fill_col   = 0;
      end
    end else begin
      if (shown_rows == 0 || shown_cols == 0) begin
        r.status = csrsms_pkg::ST_EMPTY;
      end else if (qr >= shown_rows || qc >= shown_cols) begin
        r.status = csrsms_pkg::ST_RANGE;
      end else begin
        lo = row_ptr[qr];
        hi = row_ptr[qr + 1];
        if (hi > nz_seen) hi = nz_seen;
        for (i = lo; i < hi; i++) begin
          if (nz_cols[i] == qc[csrsms_pkg::COL_W-1:0]) begin
            r.value = nz_vals[i];
            break;
          end
        end
      end
    end
    r.nz = nz_seen[csrsms_pkg::CNT_W-1:0];
    return r;
  endfunction

  function automatic logic [csrsms_pkg::VAL_W-1:0] rand_elem();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return '0;
      5: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      6: return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0000_0001;
      default: return $urandom;
    endcase
  endfunction

  // Stops sending and waits for every outstanding word; always waits on the
  // clock first, so start is never assigned twice in one step.
  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic write_dims(int rows, int cols);
    cfg_we    <= 1'b1;
    cfg_index <= csrsms_pkg::CFG_ROW_COUNT;
    cfg_wdata <= rows[csrsms_pkg::DIM_W-1:0];
    @(posedge clk);
    cfg_index <= csrsms_pkg::CFG_COL_COUNT;
    cfg_wdata <= cols[csrsms_pkg::DIM_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    dim_rows_reg = rows;
    dim_cols_reg = cols;
  endtask

  task automatic send_word(logic cmd, logic [csrsms_pkg::VAL_W-1:0] v, logic last,
                           logic [csrsms_pkg::ROW_W-1:0] qr,
                           logic [csrsms_pkg::COL_W-1:0] qc,
                           logic typed, word_result_t want);
    word_result_t pred;
    if ($urandom_range(0, 99) < 2) begin
      drain_results();
    end else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start            <= 1'b1;
    in_command       <= cmd;
    in_element_value <= v;
    in_last_element  <= last;
    in_query_row     <= qr;
    in_query_col     <= qc;
    do @(posedge clk); while (busy);
    pred = csr_predict(cmd, v, last, int'(qr), int'(qc));
    pending_results.push_back(typed ? want : pred);
    words_sent++;
  endtask

  task automatic run_phase(int rows, int cols);
    int er, ec, n, total, shape, q, k;
    drain_results();
    write_dims(rows, cols);
    er    = (rows > csrsms_pkg::MAX_ROWS) ? csrsms_pkg::MAX_ROWS : rows;
    ec    = (cols > csrsms_pkg::MAX_COLS) ? csrsms_pkg::MAX_COLS : cols;
    n     = er * ec;
    shape = $urandom_range(0, 9);
    if (n == 0)
      total = $urandom_range(1, 3);
    else if (n > 64 || shape >= 7)
      total = $urandom_range(1, (n > 40) ? 40 : n);
    else if (shape == 6)
      total = n + $urandom_range(1, 3);
    else
      total = n;
    for (k = 0; k < total; k++) begin
      if ($urandom_range(0, 99) < 8)
        send_word(csrsms_pkg::CMD_QUERY, $urandom, 1'($urandom_range(0, 1)),
                  csrsms_pkg::ROW_W'($urandom_range(0, 63)),
                  csrsms_pkg::COL_W'($urandom_range(0, 63)), 1'b0, NO_RES);
      send_word(csrsms_pkg::CMD_LOAD, rand_elem(), k == total - 1,
                csrsms_pkg::ROW_W'($urandom_range(0, 63)),
                csrsms_pkg::COL_W'($urandom_range(0, 63)), 1'b0, NO_RES);
    end
    q = $urandom_range(8, 20);
    for (k = 0; k < q; k++) begin
      if (er > 0 && ec > 0 && $urandom_range(0, 99) < 75)
        send_word(csrsms_pkg::CMD_QUERY, $urandom, 1'($urandom_range(0, 1)),
                  csrsms_pkg::ROW_W'($urandom_range(0, er - 1)),
                  csrsms_pkg::COL_W'($urandom_range(0, ec - 1)), 1'b0, NO_RES);
      else
        send_word(csrsms_pkg::CMD_QUERY, $urandom, 1'($urandom_range(0, 1)),
                  csrsms_pkg::ROW_W'($urandom_range(0, 63)),
                  csrsms_pkg::COL_W'($urandom_range(0, 63)), 1'b0, NO_RES);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word: value %h status %0d total %0d",
                   out_read_value, out_status, out_nonzero_total);
      end else begin
        head_result = pending_results.pop_front();
        if (out_read_value !== head_result.value || out_status !== head_result.status ||
            out_nonzero_total !== head_result.nz) begin
          mismatches++;
          if (mismatches <= 10)
            $display("expected value %h status %0d total %0d, got %h %0d %0d",
                     head_result.value, head_result.status, head_result.nz,
                     out_read_value, out_status, out_nonzero_total);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("csr_sparse_matrix_store_top: mismatch");
      $finish;
    end
  end

  initial begin
    int i, ph, rows, cols;
    mismatches   = 0;
    words_sent   = 0;
    cycles       = 0;
    idle_pct     = 0;
    filling      = 1'b0;
    fill_row     = 0;
    fill_col     = 0;
    nz_seen      = 0;
    fill_rows    = 0;
    fill_cols    = 0;
    shown_rows   = 0;
    shown_cols   = 0;
    dim_rows_reg = 0;
    dim_cols_reg = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (i = 0; i < DIR_LEN; i++) begin
      if (dir_tab[i].kind == DO_CFG) begin
        drain_results();
        write_dims(int'(dir_tab[i].cfg_rows), int'(dir_tab[i].cfg_cols));
      end else begin
        send_word(dir_tab[i].cmd, dir_tab[i].value, dir_tab[i].last, dir_tab[i].qr,
                  dir_tab[i].qc, dir_tab[i].typed, dir_tab[i].want);
      end
    end

    words_sent = 0;
    for (ph = 0; words_sent < RAND_WORDS; ph++) begin
      case (ph % 3)
        0: idle_pct = 0;
        1: idle_pct = 61;
        default: idle_pct = 36;
      endcase
      case (ph % 8)
        2: begin rows = 1; cols = 64; end
        4: begin rows = 64; cols = 1; end
        5: begin rows = 127; cols = 127; end
        6: begin
          if ($urandom_range(0, 1)) begin
            rows = 0;
            cols = $urandom_range(0, 127);
          end else begin
            rows = $urandom_range(0, 127);
            cols = 0;
          end
        end
        7: begin rows = $urandom_range(65, 127); cols = $urandom_range(1, 3); end
        default: begin rows = $urandom_range(1, 6); cols = $urandom_range(1, 6); end
      endcase
      run_phase(rows, cols);
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("csr_sparse_matrix_store_top: match");
    else
      $display("csr_sparse_matrix_store_top: mismatch");
    $finish;
  end

endmodule
